/* rtl/fpa_pkg.sv */
// Shared types for the fixed-point ALU: opcode encoding and response payload.
// No dependencies; compiled first.
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	typedef struct packed {
		logic [31:0] result_raw;
		logic        cond;
		logic        div_by_zero;
	} rsp_t;

endpackage

/* rtl/fpa_cmd_if.sv */
// Request channel of the fixed-point ALU: opcode and two raw operands.
// Depends on fpa_pkg for the opcode type.
interface fpa_cmd_if import fpa_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                op;
	logic signed [31:0] opnd_a;
	logic signed [31:0] opnd_b;

	modport source (output valid, output op, output opnd_a, output opnd_b, input ready);
	modport sink   (input valid, input op, input opnd_a, input opnd_b, output ready);
endinterface

/* rtl/fpa_rsp_if.sv */
// Response channel of the fixed-point ALU: raw result and flags.
// No dependencies.
interface fpa_rsp_if ();
	logic               valid;
	logic               ready;
	logic signed [31:0] result_raw;
	logic               cond;
	logic               div_by_zero;

	modport source (output valid, output result_raw, output cond, output div_by_zero,
		input ready);
	modport sink   (input valid, input result_raw, input cond, input div_by_zero,
		output ready);
endinterface

/* rtl/fixed_point_alu.sv */
// Signed fixed-point ALU, top level: operate stage, multiplier, pipelined divider, output skid.
// Depends on fpa_pkg, fpa_cmd_if and fpa_rsp_if.
//
// Takes one request per cycle while cmd.ready is high and returns one response per request,
// in order. Every request travels the same pipeline of FRAC_BITS + 36 stages: an input
// register, an operate stage with the 32x32 multiplier, a select stage, one restoring-divide
// step per quotient bit (32 + FRAC_BITS of them, one subtract each), and the output register.
// The divide chain sets the latency; throughput is one request per clock while cmd.ready is
// high. A two-entry output stage (register plus skid) freezes the pipeline only when both
// hold responses, so cmd.ready drops once the skid entry fills and rises once it moves out.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	fpa_cmd_if.sink   cmd,
	fpa_rsp_if.source rsp
);

	localparam int DW = 32 + FRAC_BITS;

	typedef struct packed {
		logic          is_div;
		logic          dz;
		logic          neg;
		logic          cond;
		logic [31:0]   res;
		logic [31:0]   rem;
		logic [DW-1:0] num;
		logic [31:0]   den;
		logic [31:0]   quo;
	} dv_t;

	logic en;

	// stage 1: input register
	logic               vld_s1;
	op_t                op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;

	// stage 2: operate
	logic               vld_s2;
	logic [31:0]        res_s2;
	logic               cond_s2;
	logic signed [63:0] prod_s2;
	logic               is_mul_s2;
	logic               is_div_s2;
	logic               dz_s2;
	logic               neg_s2;
	logic [DW-1:0]      num_s2;
	logic [31:0]        den_s2;

	logic [31:0]        res_c;
	logic               cond_c;
	logic signed [63:0] prod_c;
	logic [31:0]        amag_c;
	logic [31:0]        bmag_c;
	logic               lt_c;
	logic               gt_c;
	logic               eq_c;

	// divide chain, index 0 is the select stage
	dv_t  dv_s   [0:DW];
	logic dv_v_s [0:DW];

	rsp_t fin_c;
	rsp_t out_q;
	rsp_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic take;

	assign en        = !skid_v_q;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd.valid;
			vld_s2 <= vld_s1;
			dv_v_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= cmd.op;
			a_s1  <= cmd.opnd_a;
			b_s1  <= cmd.opnd_b;
		end
	end

	assign lt_c   = a_s1 < b_s1;
	assign gt_c   = a_s1 > b_s1;
	assign eq_c   = a_s1 == b_s1;
	assign prod_c = a_s1 * b_s1;
	assign amag_c = a_s1[31] ? (~a_s1 + 32'd1) : a_s1;
	assign bmag_c = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;

	always_comb begin
		res_c  = '0;
		cond_c = 1'b0;
		unique case (op_s1)
			OP_ADD:      res_c = a_s1 + b_s1;
			OP_SUB:      res_c = a_s1 - b_s1;
			OP_MUL:      res_c = '0;
			OP_DIV:      res_c = '0;
			OP_GT:       cond_c = gt_c;
			OP_LT:       cond_c = lt_c;
			OP_GE:       cond_c = !lt_c;
			OP_LE:       cond_c = !gt_c;
			OP_EQ:       cond_c = eq_c;
			OP_NE:       cond_c = !eq_c;
			OP_MIN:      res_c = lt_c ? a_s1 : b_s1;
			OP_MAX:      res_c = gt_c ? a_s1 : b_s1;
			OP_INC:      res_c = a_s1 + 32'sd1;
			OP_DEC:      res_c = a_s1 - 32'sd1;
			OP_FROM_INT: res_c = a_s1 << FRAC_BITS;
			OP_TO_INT:   res_c = a_s1 >>> FRAC_BITS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2    <= res_c;
			cond_s2   <= cond_c;
			prod_s2   <= prod_c;
			is_mul_s2 <= (op_s1 == OP_MUL);
			is_div_s2 <= (op_s1 == OP_DIV);
			dz_s2     <= (op_s1 == OP_DIV) && (b_s1 == 32'sd0);
			neg_s2    <= a_s1[31] ^ b_s1[31];
			num_s2    <= DW'(amag_c) << FRAC_BITS;
			den_s2    <= bmag_c;
		end
	end

	// stage 3: pick multiply result, seed the divider
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].is_div <= is_div_s2;
			dv_s[0].dz     <= dz_s2;
			dv_s[0].neg    <= neg_s2;
			dv_s[0].cond   <= cond_s2;
			dv_s[0].res    <= is_mul_s2 ? prod_s2[FRAC_BITS +: 32] : res_s2;
			dv_s[0].rem    <= '0;
			dv_s[0].num    <= num_s2;
			dv_s[0].den    <= den_s2;
			dv_s[0].quo    <= '0;
		end
	end

	// one restoring quotient bit per stage
	for (genvar k = 1; k <= DW; k++) begin : g_div
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;
		dv_t         nxt;

		assign trial = {dv_s[k-1].rem, dv_s[k-1].num[DW-1]};
		assign diff  = trial - {1'b0, dv_s[k-1].den};
		assign ge    = trial >= {1'b0, dv_s[k-1].den};

		always_comb begin
			nxt     = dv_s[k-1];
			nxt.rem = ge ? diff[31:0] : trial[31:0];
			nxt.num = dv_s[k-1].num << 1;
			nxt.quo = {dv_s[k-1].quo[30:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (en) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nxt;
			end
		end
	end

	always_comb begin
		fin_c.cond        = dv_s[DW].cond;
		fin_c.div_by_zero = dv_s[DW].dz;
		if (!dv_s[DW].is_div) begin
			fin_c.result_raw = dv_s[DW].res;
		end else if (dv_s[DW].dz) begin
			fin_c.result_raw = '0;
		end else if (dv_s[DW].neg) begin
			fin_c.result_raw = ~dv_s[DW].quo + 32'd1;
		end else begin
			fin_c.result_raw = dv_s[DW].quo;
		end
	end

	// output register plus skid entry
	assign take = out_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= dv_v_s[DW];
		end else if (dv_v_s[DW]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || take) begin
			out_q <= fin_c;
		end else begin
			skid_q <= fin_c;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.result_raw  = out_q.result_raw;
	assign rsp.cond        = out_q.cond;
	assign rsp.div_by_zero = out_q.div_by_zero;

endmodule

/* rtl/fpa_chk.sv */
// Port-level checks for the fixed-point ALU, bound to fixed_point_alu.
// Depends only on the top level's ports.
module fpa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_result_raw,
	input logic        rsp_cond,
	input logic        rsp_div_by_zero
);

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_cond && rsp_div_by_zero))
		else $error("compare and divide flags both set");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_div_by_zero) |-> (rsp_result_raw == 32'd0))
		else $error("nonzero result on divide by zero");

	a_cond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_cond) |-> (rsp_result_raw == 32'd0))
		else $error("nonzero result on compare");

	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid)
		else $error("request side stalled with no response pending");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_raw)
			&& $stable(rsp_cond) && $stable(rsp_div_by_zero)))
		else $error("response changed while stalled");

endmodule

bind fixed_point_alu fpa_chk u_fpa_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_result_raw  (rsp.result_raw),
	.rsp_cond        (rsp.cond),
	.rsp_div_by_zero (rsp.div_by_zero)
);
